### design/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro expands to one labelled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/pgmf_pkg.sv
// Package of the per-group MRU focus list: widths, defaults, codes and link types.
// Depends on nothing; the design files other than assert_macros.svh refer to it by scoped names.
package pgmf_pkg;

    // Fixed field widths.
    localparam int HANDLE_W = 32;
    localparam int MON_W    = 2;

    // Defaults for the top-level parameters.
    localparam int GROUPS_DEF = 4;
    localparam int DEPTH_DEF  = 8;

    typedef logic [HANDLE_W-1:0] t_handle;

    // Item kinds carried on the mode field.
    typedef enum logic {
        MODE_FOCUS = 1'b0,
        MODE_QUERY = 1'b1
    } t_mode;

    // Command broadcast to every cell of one group.
    typedef struct packed {
        logic    upd;
        t_handle handle;
    } t_cell_cmd;

    // What a cell hands to the next cell down the chain.
    typedef struct packed {
        logic    valid;
        logic    hit;
        t_handle entry;
    } t_link;

endpackage

### design/pgmf_cell.sv
// One cell of an MRU chain: holds one handle and its valid flag.
// Depends on pgmf_pkg for the command and link types.
module pgmf_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pgmf_pkg::t_cell_cmd i_cmd,
    input  pgmf_pkg::t_link     i_link,
    output pgmf_pkg::t_link     o_link
);

    logic              r_valid;
    logic              n_valid;
    pgmf_pkg::t_handle r_entry;
    pgmf_pkg::t_handle n_entry;
    logic              shift;
    logic              match;

    // A cell moves down one place unless the handle was already found above it.
    always_comb begin
        match   = r_valid && (r_entry == i_cmd.handle);
        shift   = i_cmd.upd && !i_link.hit;
        n_valid = shift ? i_link.valid : r_valid;
        n_entry = shift ? i_link.entry : r_entry;
    end

    // The hit flag ripples so that cells below the matching one hold still.
    assign o_link = '{valid: r_valid, hit: (i_link.hit || match), entry: r_entry};

    // Valid flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // The stored handle is payload and needs no reset.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### design/pgmf_group.sv
// MRU list of one monitor group, built as a chain of DEPTH cells.
// Depends on pgmf_pkg and pgmf_cell.
module pgmf_group #(
    parameter int DEPTH = pgmf_pkg::DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pgmf_pkg::t_cell_cmd i_cmd,
    output logic                o_front_valid,
    output pgmf_pkg::t_handle   o_front_entry
);

    pgmf_pkg::t_link link_in  [DEPTH];
    pgmf_pkg::t_link link_out [DEPTH];

    // The head of the chain offers the new handle as if it were a valid entry.
    assign link_in[0] = '{valid: 1'b1, hit: 1'b0, entry: i_cmd.handle};

    // Each cell after the first takes the output of the cell above it as its input.
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        if (k > 0) begin : g_link
            assign link_in[k] = link_out[k-1];
        end
        pgmf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (i_cmd),
            .i_link  (link_in[k]),
            .o_link  (link_out[k])
        );
    end

    // The first cell holds the most recent window of the group.
    assign o_front_valid = link_out[0].valid;
    assign o_front_entry = link_out[0].entry;

endmodule

### design/per_group_mru_focus_list_core.sv
// Per-group most-recently-used focus list: one move-to-front list per monitor group.
// Depends on pgmf_pkg and pgmf_group.
//
// The block takes one item per clock cycle unless the input stalls. A focus event
// is applied in the cycle it is accepted by the cell chain of its group: every cell
// compares its handle in parallel, the first match stops the shift below it, and the
// new handle enters at the front; the event gives no result. A query reads the front
// cell of its group and its result appears in the output register in the cycle after
// acceptance. Input stalls only while a query result waits in that register and the
// output is not ready. All lists are empty after reset; there is no clearing pass.
module per_group_mru_focus_list_core #(
    parameter int GROUPS = pgmf_pkg::GROUPS_DEF,
    parameter int DEPTH  = pgmf_pkg::DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_mode,
    input  logic [pgmf_pkg::MON_W-1:0]    i_monitor,
    input  logic [pgmf_pkg::HANDLE_W-1:0] i_window_handle,
    input  logic                          i_window_valid,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [pgmf_pkg::HANDLE_W-1:0] o_recent_window
);

    logic              accept;
    logic              is_update;
    logic              is_query;
    logic              front_valid [GROUPS];
    pgmf_pkg::t_handle front_entry [GROUPS];
    logic              q_found;
    pgmf_pkg::t_handle q_entry;

    logic              r_out_valid;
    logic              n_out_valid;
    logic              r_found;
    pgmf_pkg::t_handle r_recent;

    // Input is taken whenever the output register is free or being emptied.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign is_query   = accept && (pgmf_pkg::t_mode'(i_mode) == pgmf_pkg::MODE_QUERY);
    assign is_update  = accept && (pgmf_pkg::t_mode'(i_mode) == pgmf_pkg::MODE_FOCUS)
                        && i_window_valid && (i_window_handle != '0);

    // One cell chain per group; only the addressed group sees the update.
    for (genvar g = 0; g < GROUPS; g++) begin : g_grp
        pgmf_pkg::t_cell_cmd cmd;
        assign cmd = '{upd: (is_update && (int'(i_monitor) == g)),
                       handle: i_window_handle};
        pgmf_group #(.DEPTH(DEPTH)) u_group (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (cmd),
            .o_front_valid (front_valid[g]),
            .o_front_entry (front_entry[g])
        );
    end

    // Select the front entry of the queried group; a missing group reads as empty.
    always_comb begin
        q_found = 1'b0;
        q_entry = '0;
        for (int g = 0; g < GROUPS; g++) begin
            if (int'(i_monitor) == g) begin
                q_found = front_valid[g];
                q_entry = front_valid[g] ? front_entry[g] : '0;
            end
        end
    end

    // Output register holds a query result until it is taken.
    assign n_out_valid = is_query || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_found  <= q_found;
            r_recent <= q_entry;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_found         = r_found;
    assign o_recent_window = r_recent;

endmodule

### design/pgmf_checker.sv
// Port-level checker for the per-group MRU focus list, bound to the top level.
// Depends on pgmf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pgmf_checker #(
    parameter int GROUPS = pgmf_pkg::GROUPS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_mode,
    input logic [pgmf_pkg::MON_W-1:0]    i_monitor,
    input logic [pgmf_pkg::HANDLE_W-1:0] i_window_handle,
    input logic                          i_window_valid,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic                          o_found,
    input logic [pgmf_pkg::HANDLE_W-1:0] o_recent_window
);

    logic in_acc;
    logic q_acc;
    logic f_acc;
    logic stall;

    assign in_acc = i_in_valid && o_in_ready;
    assign q_acc  = in_acc && (pgmf_pkg::t_mode'(i_mode) == pgmf_pkg::MODE_QUERY);
    assign f_acc  = in_acc && (pgmf_pkg::t_mode'(i_mode) == pgmf_pkg::MODE_FOCUS)
                    && i_window_valid && (i_window_handle != '0)
                    && (int'(i_monitor) < GROUPS);
    assign stall  = o_out_valid && !i_out_ready;

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stall, o_out_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, stall,
        $stable(o_found) && $stable(o_recent_window))

    // An empty answer carries a null handle.
    `ASSERT_SAME(a_empty_null, i_clk, i_rst_n, o_out_valid && !o_found,
        o_recent_window == '0)

    // Every accepted query yields a result in the next cycle.
    `ASSERT_NEXT(a_query_result, i_clk, i_rst_n, q_acc, o_out_valid)

    // A query right after a focus event on the same group returns that handle.
    `ASSERT_NEXT(a_focus_front, i_clk, i_rst_n,
        q_acc && $past(f_acc) && (i_monitor == $past(i_monitor)),
        o_found && (o_recent_window == $past(i_window_handle, 2)))

endmodule

bind per_group_mru_focus_list_core pgmf_checker #(.GROUPS(GROUPS)) u_pgmf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_mode          (i_mode),
    .i_monitor       (i_monitor),
    .i_window_handle (i_window_handle),
    .i_window_valid  (i_window_valid),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_found         (o_found),
    .o_recent_window (o_recent_window)
);

### sim/tb_per_group_mru_focus_list_core.sv
// Self-checking testbench for per_group_mru_focus_list_core: directed and random items.
// Depends on pgmf_pkg and the design files; predicts each query answer as items are accepted.
`timescale 1ns / 1ps

module tb_per_group_mru_focus_list_core;

    localparam int GROUPS = pgmf_pkg::GROUPS_DEF;
    localparam int DEPTH  = pgmf_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1650;
    localparam int POOL_SIZE = 12;

    typedef logic [pgmf_pkg::MON_W-1:0] t_mon;

    // One input item as the driver presents it, with its lead-in gap.
    typedef struct {
        pgmf_pkg::t_mode    mode;
        t_mon               monitor;
        pgmf_pkg::t_handle  handle;
        logic               wvalid;
        int                 gap;
        bit                 drain;
    } t_focus_item;

    // One query answer.
    typedef struct {
        logic              found;
        pgmf_pkg::t_handle recent;
    } t_answer;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic                i_mode = 1'b0;
    t_mon                i_monitor = '0;
    pgmf_pkg::t_handle   i_window_handle = '0;
    logic                i_window_valid = 1'b0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic                o_found;
    pgmf_pkg::t_handle   o_recent_window;

    t_focus_item pending_items[$];
    t_answer     expected_answers[$];

    // Predicted lists, front entry at index 0.
    pgmf_pkg::t_handle mru_entry[GROUPS][DEPTH];
    int                mru_len[GROUPS];

    int                mismatch_count = 0;
    bit                tx_calm = 1'b0;
    pgmf_pkg::t_handle handle_pool[POOL_SIZE];

    per_group_mru_focus_list_core #(
        .GROUPS(GROUPS),
        .DEPTH (DEPTH)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_mode         (i_mode),
        .i_monitor      (i_monitor),
        .i_window_handle(i_window_handle),
        .i_window_valid (i_window_valid),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_recent_window(o_recent_window)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Applies one accepted item to the predicted lists; a query queues its answer.
    task automatic mru_apply(input t_focus_item it);
        int      g;
        int      n;
        int      pos;
        t_answer ans;
        g = it.monitor;
        if (it.mode == pgmf_pkg::MODE_FOCUS) begin
            if (it.wvalid && it.handle != '0 && g < GROUPS) begin
                n = mru_len[g];
                pos = n;
                for (int k = 0; k < n; k++) begin
                    if (pos == n && mru_entry[g][k] == it.handle) pos = k;
                end
                // A handle not in the list grows it, or pushes the oldest out when full.
                if (pos == n) begin
                    if (n < DEPTH) n++;
                    pos = n - 1;
                end
                for (int k = pos; k > 0; k--) mru_entry[g][k] = mru_entry[g][k-1];
                mru_entry[g][0] = it.handle;
                mru_len[g] = n;
            end
        end else begin
            if (g < GROUPS && mru_len[g] != 0) begin
                ans.found = 1'b1;
                ans.recent = mru_entry[g][0];
            end else begin
                ans.found = 1'b0;
                ans.recent = '0;
            end
            expected_answers = {expected_answers, ans};
        end
    endtask

    task automatic report_mismatch(input string what, input pgmf_pkg::t_handle got,
                                   input pgmf_pkg::t_handle want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Queues one item; its gap follows the current sender phase.
    task automatic add_item(input pgmf_pkg::t_mode mode, input t_mon mon,
                            input pgmf_pkg::t_handle handle, input logic wvalid,
                            input bit drain);
        t_focus_item it;
        it.mode = mode;
        it.monitor = mon;
        it.handle = handle;
        it.wvalid = wvalid;
        it.drain = drain;
        it.gap = tx_calm ? 0 : int'($urandom_range(0, 16));
        pending_items = {pending_items, it};
    endtask

    // Driver: presents queued items, holding each until it is accepted.
    int wait_left = 0;
    bit gap_loaded = 1'b0;
    always @(posedge i_clk) begin
        t_focus_item it;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                it.mode = pgmf_pkg::t_mode'(i_mode);
                it.monitor = i_monitor;
                it.handle = i_window_handle;
                it.wvalid = i_window_valid;
                mru_apply(it);
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_items.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else begin
                    if (!gap_loaded) begin
                        wait_left = pending_items[0].gap;
                        gap_loaded = 1'b1;
                    end
                    if (wait_left > 0) begin
                        wait_left--;
                        i_in_valid <= 1'b0;
                    end else if (pending_items[0].drain && expected_answers.size() != 0) begin
                        // Hold off until every outstanding answer has come back.
                        i_in_valid <= 1'b0;
                    end else begin
                        it = pending_items.pop_front();
                        gap_loaded = 1'b0;
                        i_in_valid <= 1'b1;
                        i_mode <= it.mode;
                        i_monitor <= it.monitor;
                        i_window_handle <= it.handle;
                        i_window_valid <= it.wvalid;
                    end
                end
            end
        end
    end

    // Monitor: checks each accepted answer and draws the stall before the next one.
    int hold_left = 0;
    int answer_count = 0;
    bit rx_calm = 1'b0;
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer", o_recent_window, '0);
                end else begin
                    want = expected_answers.pop_front();
                    if (o_found !== want.found)
                        report_mismatch("found", pgmf_pkg::t_handle'(o_found),
                                        pgmf_pkg::t_handle'(want.found));
                    if (o_recent_window !== want.recent)
                        report_mismatch("recent_window", o_recent_window, want.recent);
                end
                answer_count++;
                if (answer_count % 64 == 0) rx_calm = !rx_calm;
                hold_left = rx_calm ? 0 : int'($urandom_range(0, 16));
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int r;
        int g;
        for (int gi = 0; gi < GROUPS; gi++) begin
            mru_len[gi] = 0;
            for (int k = 0; k < DEPTH; k++) mru_entry[gi][k] = '0;
        end

        // Directed part: empty lists, extreme handles, ignored events, overflow, hit.
        tx_calm = 1'b1;
        for (int gi = 0; gi < 4; gi++)
            add_item(pgmf_pkg::MODE_QUERY, t_mon'(gi), '0, 1'b0, 1'b0);
        add_item(pgmf_pkg::MODE_FOCUS, 2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        add_item(pgmf_pkg::MODE_QUERY, 2'd0, 32'hFFFF_FFFF, 1'b1, 1'b0);
        // A null handle and an invalid event leave their lists empty.
        add_item(pgmf_pkg::MODE_FOCUS, 2'd1, '0, 1'b1, 1'b0);
        add_item(pgmf_pkg::MODE_QUERY, 2'd1, '0, 1'b1, 1'b0);
        add_item(pgmf_pkg::MODE_FOCUS, 2'd2, 32'h0000_0005, 1'b0, 1'b0);
        add_item(pgmf_pkg::MODE_QUERY, 2'd2, '0, 1'b0, 1'b0);
        // One more handle than the depth: the oldest is pushed out.
        for (int k = 0; k <= DEPTH; k++)
            add_item(pgmf_pkg::MODE_FOCUS, 2'd3, (k == 0) ? 32'h1 : 32'h8000_0000 + k,
                     1'b1, 1'b0);
        add_item(pgmf_pkg::MODE_QUERY, 2'd3, '0, 1'b0, 1'b0);
        // Refocusing an entry in the middle moves it back to the front.
        add_item(pgmf_pkg::MODE_FOCUS, 2'd3, 32'h8000_0004, 1'b1, 1'b0);
        add_item(pgmf_pkg::MODE_QUERY, 2'd3, 32'hFFFF_FFFF, 1'b0, 1'b0);

        // A small shared pool of handles so that hits and evictions are frequent.
        handle_pool[0] = 32'hFFFF_FFFF;
        handle_pool[1] = 32'h0000_0001;
        for (int k = 2; k < POOL_SIZE; k++) begin
            handle_pool[k] = $urandom;
            if (handle_pool[k] == '0) handle_pool[k] = 32'h5A5A_5A5A;
        end

        // Random part: mostly well-formed focus events and queries, some noise.
        tx_calm = 1'b0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 120 == 0) tx_calm = !tx_calm;
            r = $urandom_range(0, 99);
            g = $urandom_range(0, 3);
            if (r < 30)
                add_item(pgmf_pkg::MODE_QUERY, t_mon'(g), $urandom,
                         1'($urandom_range(0, 1)), i % 400 == 200);
            else if (r < 80)
                add_item(pgmf_pkg::MODE_FOCUS, t_mon'(g),
                         handle_pool[$urandom_range(0, POOL_SIZE-1)], 1'b1, i % 400 == 200);
            else if (r < 88)
                add_item(pgmf_pkg::MODE_FOCUS, t_mon'(g), $urandom, 1'b1, i % 400 == 200);
            else if (r < 94)
                add_item(pgmf_pkg::MODE_FOCUS, t_mon'(g),
                         handle_pool[$urandom_range(0, POOL_SIZE-1)], 1'b0, i % 400 == 200);
            else
                add_item(pgmf_pkg::MODE_FOCUS, t_mon'(g), '0, 1'b1, i % 400 == 200);
        end
        add_item(pgmf_pkg::MODE_QUERY, 2'd0, '0, 1'b0, 1'b0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || i_in_valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_answers.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #800000;
        $display("[%0t] timeout", $time);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
